### src/fdcc_pkg.sv
package fdcc_pkg;

    localparam int HEADER_BYTES = 7;

    localparam logic [15:0] HDR_END       = 16'(HEADER_BYTES);
    localparam logic [15:0] HDR_CRC_HI    = 16'(HEADER_BYTES + 1);
    localparam logic [15:0] MIN_FRAME_LEN = 16'(HEADER_BYTES + 6);
    localparam logic [15:0] LEN_LO_IDX    = 16'd2;
    localparam logic [15:0] LEN_HI_IDX    = 16'd3;
    localparam logic [15:0] BODY_MIN_IDX  = 16'd4;

    localparam logic [15:0] HDR_POLY  = 16'h8408;
    localparam logic [31:0] BODY_POLY = 32'hEDB88320;

    localparam logic [15:0] HDR_SEED_RST  = 16'h4C49;
    localparam logic [31:0] BODY_SEED_RST = 32'h564F580A;
    localparam logic [15:0] MAX_LEN_RST   = 16'd1404;

    localparam logic [1:0] REG_HDR_SEED  = 2'd0;
    localparam logic [1:0] REG_BODY_SEED = 2'd1;
    localparam logic [1:0] REG_MAX_LEN   = 2'd2;

    localparam logic [1:0] ST_CHECKED   = 2'd0;
    localparam logic [1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [1:0] ST_CUT_SHORT = 2'd2;

    typedef struct packed {
        logic [15:0] hdr_seed;
        logic [31:0] body_seed;
        logic [15:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [1:0]  status;
        logic        body_ok;
        logic        header_ok;
        logic        passed;
    } t_result;

    function automatic logic [15:0] hdr_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ HDR_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [31:0] body_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ BODY_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

### src/fdcc_cfg.sv
module fdcc_cfg
    import fdcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [1:0]  i_index,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_seed  <= HDR_SEED_RST;
            r_cfg.body_seed <= BODY_SEED_RST;
            r_cfg.max_len   <= MAX_LEN_RST;
        end else if (i_wr) begin
            case (i_index)
                REG_HDR_SEED:  r_cfg.hdr_seed  <= i_data[15:0];
                REG_BODY_SEED: r_cfg.body_seed <= i_data;
                REG_MAX_LEN:   r_cfg.max_len   <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/fdcc_frame.sv
module fdcc_frame
    import fdcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_octet,
    input  logic       i_start,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic        r_in_frame;
    logic [15:0] r_count;
    logic [15:0] r_len;
    logic [15:0] r_hcrc;
    logic [31:0] r_bcrc;
    logic [15:0] r_rx_hcrc;
    logic [31:0] r_rx_bcrc;

    logic        n_in_frame;
    logic [15:0] n_count;
    logic [15:0] n_len;
    logic [15:0] n_hcrc;
    logic [31:0] n_bcrc;
    logic [15:0] n_rx_hcrc;
    logic [31:0] n_rx_bcrc;

    logic        active;
    logic [15:0] idx;
    logic [15:0] len_cur;
    logic [15:0] hcrc_cur;
    logic [31:0] bcrc_cur;
    logic [15:0] rx_hcrc_cur;
    logic [31:0] rx_bcrc_cur;
    logic        bad_len;
    logic        done;
    logic        in_body;
    logic        cut;
    logic        hok;
    logic        bok;

    always_comb begin
        active      = i_start | r_in_frame;
        cut         = i_start & r_in_frame;
        idx         = i_start ? 16'd0 : r_count;
        len_cur     = i_start ? 16'd0 : r_len;
        hcrc_cur    = i_start ? i_cfg.hdr_seed : r_hcrc;
        bcrc_cur    = i_start ? ~i_cfg.body_seed : r_bcrc;
        rx_hcrc_cur = i_start ? 16'd0 : r_rx_hcrc;
        rx_bcrc_cur = i_start ? 32'd0 : r_rx_bcrc;

        n_len = len_cur;
        if (idx == LEN_LO_IDX) begin
            n_len = {len_cur[15:8], i_octet};
        end else if (idx == LEN_HI_IDX) begin
            n_len = {i_octet, len_cur[7:0]};
        end

        n_hcrc    = hcrc_cur;
        n_rx_hcrc = rx_hcrc_cur;
        if (idx < HDR_END) begin
            n_hcrc = hdr_update(hcrc_cur, i_octet);
        end else if (idx == HDR_END) begin
            n_rx_hcrc = {rx_hcrc_cur[15:8], i_octet};
        end else if (idx == HDR_CRC_HI) begin
            n_rx_hcrc = {i_octet, rx_hcrc_cur[7:0]};
        end

        bad_len = (idx == LEN_HI_IDX) &&
                  ((n_len < MIN_FRAME_LEN) || (n_len > i_cfg.max_len));

        in_body   = (idx <= LEN_HI_IDX) || (({1'b0, idx} + 17'd4) < {1'b0, n_len});
        n_bcrc    = in_body ? body_update(bcrc_cur, i_octet) : bcrc_cur;
        n_rx_bcrc = in_body ? rx_bcrc_cur : {i_octet, rx_bcrc_cur[31:8]};

        done = !bad_len && (idx >= BODY_MIN_IDX) &&
               (({1'b0, idx} + 17'd1) == {1'b0, n_len});
        hok  = (n_hcrc == n_rx_hcrc);
        bok  = (~n_bcrc == n_rx_bcrc);

        n_in_frame = active && !bad_len && !done;
        n_count    = idx + 16'd1;

        o_res_valid = i_accept && (cut || (active && (bad_len || done)));
        o_res       = '0;
        if (cut) begin
            o_res.status       = ST_CUT_SHORT;
            o_res.frame_length = r_len;
        end else if (bad_len) begin
            o_res.status       = ST_BAD_LEN;
            o_res.frame_length = n_len;
        end else begin
            o_res.status       = ST_CHECKED;
            o_res.frame_length = n_len;
            o_res.header_ok    = hok;
            o_res.body_ok      = bok;
            o_res.passed       = hok & bok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_len      <= '0;
            r_hcrc     <= '0;
            r_bcrc     <= '0;
            r_rx_hcrc  <= '0;
            r_rx_bcrc  <= '0;
        end else if (i_accept && active) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_len      <= n_len;
            r_hcrc     <= n_hcrc;
            r_bcrc     <= n_bcrc;
            r_rx_hcrc  <= n_rx_hcrc;
            r_rx_bcrc  <= n_rx_bcrc;
        end
    end

endmodule

### src/frame_dual_crc_checker_unit.sv
// Channel   Direction  Contents
// s_axis    in         tdata: octet[7:0]; tuser: frame_start
// m_axis    out        tdata: passed, header_ok, body_ok, status[1:0], frame_length[15:0]
// cfg       in         index 0 header seed, 1 body seed, 2 max frame length
//
// One byte per cycle while s_axis is not stalled; each byte updates the CRC state in the cycle it is taken.
// A verdict appears on m_axis in the cycle after the byte that ends its frame.
// Output register drains while new bytes enter; s_axis stalls only when the
// verdict register is full and m_axis is not ready.
// Synchronous active-low reset restores register defaults and closes any frame.
module frame_dual_crc_checker_unit
    import fdcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // octet[7:0]
    input  logic        i_s_axis_tuser,   // frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // passed, header_ok, body_ok, status[4:3],
                                          // frame_length[20:5], zero[23:21]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    accept;
    logic    r_out_valid;
    t_result r_out;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    fdcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    fdcc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_octet     (i_s_axis_tdata),
        .i_start     (i_s_axis_tuser),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out};

endmodule

### sim/tb_frame_dual_crc_checker_unit.sv
module tb_frame_dual_crc_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fdcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 200;

    typedef struct packed {
        logic       start;
        logic [7:0] octet;
    } t_octet_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = REG_HDR_SEED;
    logic [31:0] cfg_data = 32'h0;
    logic        s_ready;
    logic        m_valid;
    logic [23:0] m_data;
    logic        cfg_ready;

    t_octet_word word_q[$];
    t_result     verdict_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;

    t_cfg        cfg_shadow = '{hdr_seed: HDR_SEED_RST, body_seed: BODY_SEED_RST,
                                max_len: MAX_LEN_RST};
    logic        open_frame = 1'b0;
    logic [15:0] byte_idx = '0;
    logic [15:0] len_field = '0;
    logic [15:0] hdr_crc_run = '0;
    logic [31:0] body_crc_run = '0;
    logic [15:0] hdr_crc_rx = '0;
    logic [31:0] body_crc_rx = '0;

    frame_dual_crc_checker_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_mcrf_byte(logic [15:0] c, logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[k];
            c = c >> 1;
            if (fb) c = c ^ 16'h8408;
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_refl_byte(logic [31:0] c, logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[k];
            c = c >> 1;
            if (fb) c = c ^ 32'hEDB88320;
        end
        return c;
    endfunction

    function automatic void push_verdict(logic hok, logic bok, logic [1:0] st);
        t_result r;
        r.passed = hok & bok;
        r.header_ok = hok;
        r.body_ok = bok;
        r.status = st;
        r.frame_length = len_field;
        verdict_q.push_back(r);
    endfunction

    function automatic void track_byte(t_octet_word w);
        logic [7:0] d;
        int idx;
        d = w.octet;
        if (w.start) begin
            if (open_frame) push_verdict(1'b0, 1'b0, ST_CUT_SHORT);
            open_frame = 1'b1;
            byte_idx = '0;
            len_field = '0;
            hdr_crc_run = cfg_shadow.hdr_seed;
            body_crc_run = ~cfg_shadow.body_seed;
            hdr_crc_rx = '0;
            body_crc_rx = '0;
        end
        if (open_frame) begin
            idx = int'(byte_idx);
            if (byte_idx == LEN_LO_IDX) len_field[7:0] = d;
            else if (byte_idx == LEN_HI_IDX) len_field[15:8] = d;
            if (byte_idx < HDR_END) hdr_crc_run = crc16_mcrf_byte(hdr_crc_run, d);
            else if (byte_idx == HDR_END) hdr_crc_rx[7:0] = d;
            else if (byte_idx == HDR_CRC_HI) hdr_crc_rx[15:8] = d;
            if (byte_idx == LEN_HI_IDX &&
                (len_field < MIN_FRAME_LEN || len_field > cfg_shadow.max_len)) begin
                push_verdict(1'b0, 1'b0, ST_BAD_LEN);
                open_frame = 1'b0;
            end else begin
                if (byte_idx <= LEN_HI_IDX || idx + 4 < int'(len_field)) begin
                    body_crc_run = crc32_refl_byte(body_crc_run, d);
                end else begin
                    body_crc_rx = {d, body_crc_rx[31:8]};
                end
                if (byte_idx >= BODY_MIN_IDX && idx + 1 == int'(len_field)) begin
                    push_verdict(hdr_crc_run == hdr_crc_rx, (~body_crc_run) == body_crc_rx,
                                 ST_CHECKED);
                    open_frame = 1'b0;
                end else begin
                    byte_idx = byte_idx + 16'd1;
                end
            end
        end
    endfunction

    function automatic int queue_frame(int flen, int keep, int flip_at);
        logic [7:0]  fbytes[];
        logic [15:0] h;
        logic [31:0] b;
        int sz;
        sz = (keep > int'(MIN_FRAME_LEN)) ? keep : int'(MIN_FRAME_LEN);
        fbytes = new[sz];
        foreach (fbytes[i]) fbytes[i] = 8'($urandom);
        fbytes[2] = flen[7:0];
        fbytes[3] = flen[15:8];
        h = cfg_shadow.hdr_seed;
        for (int i = 0; i < HEADER_BYTES; i++) h = crc16_mcrf_byte(h, fbytes[i]);
        fbytes[HEADER_BYTES] = h[7:0];
        fbytes[HEADER_BYTES + 1] = h[15:8];
        if (keep == flen && flen >= int'(MIN_FRAME_LEN)) begin
            b = ~cfg_shadow.body_seed;
            for (int i = 0; i + 4 < flen; i++) b = crc32_refl_byte(b, fbytes[i]);
            b = ~b;
            for (int i = 0; i < 4; i++) fbytes[flen - 4 + i] = b[8*i +: 8];
        end
        if (flip_at >= 0) fbytes[flip_at] = fbytes[flip_at] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < keep; i++) word_q.push_back('{start: (i == 0), octet: fbytes[i]});
        return keep;
    endfunction

    task automatic drain_all();
        while (word_q.size() != 0 || s_valid || verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_config(logic [15:0] hs, logic [31:0] bs, logic [15:0] ml);
        logic [31:0] vals[3];
        logic [1:0]  idxs[3];
        vals[0] = {16'h0, hs};
        vals[1] = bs;
        vals[2] = {16'h0, ml};
        idxs[0] = REG_HDR_SEED;
        idxs[1] = REG_BODY_SEED;
        idxs[2] = REG_MAX_LEN;
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[k];
            cfg_data <= vals[k];
            @(posedge i_clk);
            while (!cfg_ready) @(posedge i_clk);
        end
        cfg_valid <= 1'b0;
        cfg_shadow.hdr_seed = hs;
        cfg_shadow.body_seed = bs;
        cfg_shadow.max_len = ml;
    endtask

    always @(posedge i_clk) begin
        t_octet_word w;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            open_frame = 1'b0;
        end else begin
            if (s_valid && s_ready) track_byte('{start: s_user, octet: s_data});
            if (!s_valid || s_ready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = word_q.pop_front();
                    s_valid <= 1'b1;
                    s_data <= w.octet;
                    s_user <= w.start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_v;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = t_result'(m_data[20:0]);
                if (verdict_q.size() == 0) begin
                    if (err_cnt < 10) begin
                        $display("unexpected verdict: passed=%0d hok=%0d bok=%0d st=%0d len=%0d",
                                 got.passed, got.header_ok, got.body_ok, got.status,
                                 got.frame_length);
                    end
                    err_cnt++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (got !== exp_v) begin
                        if (err_cnt < 10) begin
                            $display("verdict mismatch: exp passed=%0d hok=%0d bok=%0d st=%0d len=%0d",
                                     exp_v.passed, exp_v.header_ok, exp_v.body_ok,
                                     exp_v.status, exp_v.frame_length);
                            $display("                  got passed=%0d hok=%0d bok=%0d st=%0d len=%0d",
                                     got.passed, got.header_ok, got.body_ok, got.status,
                                     got.frame_length);
                        end
                        err_cnt++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int used;
        int pick;
        int flen;
        int lim;
        logic [15:0] hs;
        logic [15:0] ml;
        logic [31:0] bs;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        void'(queue_frame(MIN_FRAME_LEN, MIN_FRAME_LEN, -1));
        word_q.push_back('{start: 1'b0, octet: 8'hFF});
        void'(queue_frame(MIN_FRAME_LEN - 1, 4, -1));
        void'(queue_frame(65535, 4, -1));
        void'(queue_frame(20, 3, -1));

        for (int p = 0; p < 8; p++) begin
            if (p != 0) drain_all();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            hs = 16'($urandom);
            bs = $urandom;
            case (p)
                0: begin hs = HDR_SEED_RST; bs = BODY_SEED_RST; ml = MAX_LEN_RST; end
                1: begin hs = 16'h0000; bs = 32'h0; ml = MIN_FRAME_LEN; end
                2: begin hs = 16'hFFFF; bs = 32'hFFFFFFFF; ml = 16'hFFFF; end
                3: ml = MIN_FRAME_LEN - 16'd1;
                4: ml = 16'($urandom_range(MIN_FRAME_LEN, 200));
                5: ml = 16'($urandom_range(MIN_FRAME_LEN, 65535));
                6: ml = MIN_FRAME_LEN + 16'd1;
                default: begin hs = HDR_SEED_RST; bs = BODY_SEED_RST; ml = MAX_LEN_RST; end
            endcase
            if (p != 0) load_config(hs, bs, ml);

            used = 0;
            if (ml >= MIN_FRAME_LEN && ml <= 16'd300) used += queue_frame(ml, ml, -1);
            if (ml == 16'hFFFF) used += queue_frame(65535, 20, -1);
            while (used < PHASE_BYTES) begin
                pick = $urandom_range(99);
                lim = (ml > 16'd40) ? 40 : int'(ml);
                if ($urandom_range(19) == 0) lim = (ml > 16'd300) ? 300 : int'(ml);
                flen = (ml >= MIN_FRAME_LEN) ? $urandom_range(MIN_FRAME_LEN, lim) : 0;
                if (ml < MIN_FRAME_LEN || (pick >= 85 && pick < 93)) begin
                    if (ml < MIN_FRAME_LEN) flen = $urandom_range(65535);
                    else if (ml == 16'hFFFF || $urandom_range(1) == 0)
                        flen = $urandom_range(MIN_FRAME_LEN - 1);
                    else flen = $urandom_range(int'(ml) + 1, 65535);
                    void'(queue_frame(flen, 4 + $urandom_range(3), -1));
                    used += 4;
                end else if (pick < 60) begin
                    used += queue_frame(flen, flen, -1);
                end else if (pick < 75) begin
                    used += queue_frame(flen, flen, $urandom_range(flen - 1));
                end else if (pick < 85) begin
                    used += queue_frame(flen, $urandom_range(1, flen - 1), -1);
                end else begin
                    repeat ($urandom_range(1, 3))
                        word_q.push_back('{start: 1'b0, octet: 8'($urandom)});
                end
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_all();
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
src/fdcc_pkg.sv
src/fdcc_cfg.sv
src/fdcc_frame.sv
src/frame_dual_crc_checker_unit.sv
sim/tb_frame_dual_crc_checker_unit.sv
